[src/cks_pkg.sv]
// Shared types, character codes and keyword tables for the keyword scorer.
// Used by cks_front, cks_queue, cks_back and cognitive_keyword_scorer.
package cks_pkg;

  // Bytes carried with each judged position: the head and six bytes after it.
  localparam int LOOK_BYTES = 7;
  localparam int AVAIL_BITS = 3;

  // Character codes that steer the scoring.
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_S      = 8'h73;

  // One head position handed from the front to the back. The avail field
  // counts bytes held from the head on, held at seven when there are more.
  typedef struct packed {
    logic [LOOK_BYTES-1:0][7:0] text;
    logic [AVAIL_BITS-1:0]      avail;
    logic                       last;
  } item_t;

  typedef enum logic [3:0] {
    KW_IF,
    KW_ELSE,
    KW_WHILE,
    KW_FOR,
    KW_DO,
    KW_SWITCH,
    KW_CATCH,
    KW_GOTO,
    KW_BREAK
  } kw_id_t;

  function automatic logic is_alnum(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [2:0] kw_len(kw_id_t id);
    logic [2:0] len;
    case (id)
      KW_IF, KW_DO:                   len = 3'd2;
      KW_FOR:                         len = 3'd3;
      KW_ELSE, KW_GOTO:               len = 3'd4;
      KW_WHILE, KW_CATCH, KW_BREAK:   len = 3'd5;
      KW_SWITCH:                      len = 3'd6;
      default:                        len = 3'd7;
    endcase
    return len;
  endfunction

  // Keyword spelling, first character in element zero.
  function automatic logic [5:0][7:0] kw_text(kw_id_t id);
    logic [5:0][7:0] t;
    t = '0;
    case (id)
      KW_IF: begin
        t[0] = "i"; t[1] = "f";
      end
      KW_ELSE: begin
        t[0] = "e"; t[1] = "l"; t[2] = "s"; t[3] = "e";
      end
      KW_WHILE: begin
        t[0] = "w"; t[1] = "h"; t[2] = "i"; t[3] = "l"; t[4] = "e";
      end
      KW_FOR: begin
        t[0] = "f"; t[1] = "o"; t[2] = "r";
      end
      KW_DO: begin
        t[0] = "d"; t[1] = "o";
      end
      KW_SWITCH: begin
        t[0] = "s"; t[1] = "w"; t[2] = "i"; t[3] = "t"; t[4] = "c"; t[5] = "h";
      end
      KW_CATCH: begin
        t[0] = "c"; t[1] = "a"; t[2] = "t"; t[3] = "c"; t[4] = "h";
      end
      KW_GOTO: begin
        t[0] = "g"; t[1] = "o"; t[2] = "t"; t[3] = "o";
      end
      KW_BREAK: begin
        t[0] = "b"; t[1] = "r"; t[2] = "e"; t[3] = "a"; t[4] = "k";
      end
      default: t = '0;
    endcase
    return t;
  endfunction

  // Keywords that add one on top of the nesting level.
  function automatic logic kw_plus_one(kw_id_t id);
    return (id == KW_IF) || (id == KW_WHILE) || (id == KW_FOR) ||
           (id == KW_DO) || (id == KW_SWITCH) || (id == KW_CATCH);
  endfunction

  // Spelling matches, the keyword fits before the end of text, and the byte
  // after it does not continue a word.
  function automatic logic kw_fits(logic [LOOK_BYTES-1:0][7:0] text,
                                   logic [AVAIL_BITS-1:0] avail, kw_id_t id);
    logic            hit;
    logic [2:0]      len;
    logic [5:0][7:0] kw;
    logic [7:0]      nx;
    len = kw_len(id);
    kw  = kw_text(id);
    hit = (avail >= len);
    for (int i = 0; i < 6; i++) begin
      if ((3'(i) < len) && (text[i] != kw[i])) begin
        hit = 1'b0;
      end
    end
    nx = text[len];
    if ((avail > len) && (is_alnum(nx) || nx == CH_UNDER)) begin
      hit = 1'b0;
    end
    return hit;
  endfunction

endpackage

[src/cks_front.sv]
// Front part of the keyword scorer: gathers bytes into an eight-byte window
// and issues head positions to the queue. Depends on cks_pkg.
module cks_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       text_byte,
  input  logic             final_byte,
  input  logic             q_full,
  output logic             q_push,
  output cks_pkg::item_t   q_item
);

  logic [7:0][7:0] win;
  logic [7:0][7:0] win_next;
  logic [3:0]      fill;
  logic [3:0]      fill_next;
  logic            draining;
  logic            draining_next;
  logic            accept;
  logic            drain_step;

  // The input stalls while the end of a text drains or the queue is full.
  assign full       = draining || q_full;
  assign accept     = push && !full;
  assign drain_step = draining && !q_full;

  // Issue a head position: one per byte in steady flow, then one per cycle
  // while the tail of a text drains and the queue is not full.
  always_comb begin
    q_item.text = win[cks_pkg::LOOK_BYTES-1:0];
    if (draining) begin
      q_push       = drain_step;
      q_item.avail = (fill >= 4'd7) ? 3'd7 : fill[2:0];
      q_item.last  = (fill == 4'd1);
    end else begin
      q_push       = accept && !final_byte && (fill == 4'd7);
      q_item.avail = 3'd7;
      q_item.last  = 1'b0;
    end
  end

  // Window, fill count and drain flag updates.
  always_comb begin
    win_next      = win;
    fill_next     = fill;
    draining_next = draining;
    if (drain_step) begin
      for (int i = 0; i < 7; i++) begin
        win_next[i] = win[i+1];
      end
      win_next[7] = 8'h00;
      fill_next   = fill - 4'd1;
      if (fill == 4'd1) begin
        draining_next = 1'b0;
      end
    end else if (accept) begin
      if (!final_byte && fill == 4'd7) begin
        for (int i = 0; i < 6; i++) begin
          win_next[i] = win[i+1];
        end
        win_next[6] = text_byte;
      end else begin
        win_next[fill[2:0]] = text_byte;
        fill_next           = fill + 4'd1;
      end
      if (final_byte) begin
        draining_next = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      draining <= 1'b0;
    end else begin
      fill     <= fill_next;
      draining <= draining_next;
    end
  end

  // Window bytes.
  always_ff @(posedge clk) begin
    win <= win_next;
  end

endmodule

[src/cks_queue.sv]
// Short queue of head positions between the front and back parts.
// Depends on cks_pkg for the entry type.
module cks_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  cks_pkg::item_t wr_item,
  output logic           q_full,
  input  logic           rd_en,
  output cks_pkg::item_t rd_item,
  output logic           q_empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  cks_pkg::item_t        slots [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [CNT_BITS-1:0]   count;
  logic                  do_wr;
  logic                  do_rd;

  assign q_full  = (count == CNT_BITS'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_item = slots[rd_ptr];

  // Pointer and occupancy tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

[src/cks_back.sv]
// Back part of the keyword scorer: judges one head position per cycle, a text's closing one
// only with the output free; tracks nesting and score, holds the finished score. Depends on cks_pkg.
module cks_back #(
  parameter int SCORE_BITS = 24,
  parameter int NEST_BITS  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  cks_pkg::item_t        q_item,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output logic [SCORE_BITS-1:0] score
);

  localparam int SUM_BITS = ((SCORE_BITS > NEST_BITS) ? SCORE_BITS : NEST_BITS) + 1;
  localparam logic [SCORE_BITS-1:0] SCORE_MAX = {SCORE_BITS{1'b1}};
  localparam logic [NEST_BITS-1:0]  NEST_MAX  = {NEST_BITS{1'b1}};

  logic [NEST_BITS-1:0]  nest;
  logic [NEST_BITS-1:0]  nest_next;
  logic [SCORE_BITS-1:0] run_score;
  logic [SCORE_BITS-1:0] run_score_next;
  logic [2:0]            skip;
  logic [2:0]            skip_next;
  logic                  prev_alnum;
  logic                  s_seen;
  logic                  out_valid;
  logic                  take;
  logic [7:0]            head;

  logic                  kw_found;
  cks_pkg::kw_id_t       kw_id;
  logic                  kw_hit;
  logic                  add_en;
  logic                  add_one;
  logic [SUM_BITS-1:0]   sum;

  // A head position is taken unless it closes a text and the output is busy.
  assign head  = q_item.text[0];
  assign take  = !q_empty && (!q_item.last || !out_valid || pop);
  assign q_pop = take;
  assign empty = !out_valid;

  // Keyword candidate by its first character.
  always_comb begin
    kw_found = 1'b1;
    case (head)
      "i":     kw_id = cks_pkg::KW_IF;
      "e":     kw_id = cks_pkg::KW_ELSE;
      "w":     kw_id = cks_pkg::KW_WHILE;
      "f":     kw_id = cks_pkg::KW_FOR;
      "d":     kw_id = cks_pkg::KW_DO;
      "s":     kw_id = cks_pkg::KW_SWITCH;
      "c":     kw_id = cks_pkg::KW_CATCH;
      "g":     kw_id = cks_pkg::KW_GOTO;
      "b":     kw_id = cks_pkg::KW_BREAK;
      default: begin
        kw_id    = cks_pkg::KW_IF;
        kw_found = 1'b0;
      end
    endcase
    kw_hit = kw_found && !prev_alnum &&
             cks_pkg::kw_fits(q_item.text, q_item.avail, kw_id) &&
             ((kw_id != cks_pkg::KW_BREAK) || s_seen);
  end

  // Judge the head byte unless it belongs to an earlier match.
  always_comb begin
    nest_next = nest;
    skip_next = skip;
    add_en    = 1'b0;
    add_one   = 1'b0;
    if (skip != 3'd0) begin
      skip_next = skip - 3'd1;
    end else begin
      case (head)
        cks_pkg::CH_LBRACE: begin
          if (nest != NEST_MAX) begin
            nest_next = nest + 1'b1;
          end
        end
        cks_pkg::CH_RBRACE: begin
          if (nest != '0) begin
            nest_next = nest - 1'b1;
          end
        end
        cks_pkg::CH_AMP, cks_pkg::CH_BAR: begin
          if (q_item.avail >= 3'd2 && q_item.text[1] == head) begin
            add_en    = 1'b1;
            skip_next = 3'd1;
          end
        end
        default: begin
          if (kw_hit) begin
            add_en    = 1'b1;
            add_one   = cks_pkg::kw_plus_one(kw_id);
            skip_next = cks_pkg::kw_len(kw_id) - 3'd1;
          end
        end
      endcase
    end
  end

  // Saturating score update.
  always_comb begin
    sum = SUM_BITS'(run_score) + SUM_BITS'(nest) + SUM_BITS'(add_one);
    if (!add_en) begin
      run_score_next = run_score;
    end else if (sum > SUM_BITS'(SCORE_MAX)) begin
      run_score_next = SCORE_MAX;
    end else begin
      run_score_next = sum[SCORE_BITS-1:0];
    end
  end

  // Text state; the closing position returns it to the start of a text.
  always_ff @(posedge clk) begin
    if (rst) begin
      nest       <= '0;
      run_score  <= '0;
      skip       <= '0;
      prev_alnum <= 1'b0;
      s_seen     <= 1'b0;
    end else if (take) begin
      if (q_item.last) begin
        nest       <= '0;
        run_score  <= '0;
        skip       <= '0;
        prev_alnum <= 1'b0;
        s_seen     <= 1'b0;
      end else begin
        nest       <= nest_next;
        run_score  <= run_score_next;
        skip       <= skip_next;
        prev_alnum <= cks_pkg::is_alnum(head);
        if (head == cks_pkg::CH_LF) begin
          s_seen <= 1'b0;
        end else if (head == cks_pkg::CH_S) begin
          s_seen <= 1'b1;
        end
      end
    end
  end

  // Output register: holds the finished score until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && q_item.last) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_item.last) begin
      score <= run_score_next;
    end
  end

endmodule

[src/cognitive_keyword_scorer.sv]
// Top level of the keyword complexity scorer: front window, position queue
// and back judge. Depends on cks_pkg, cks_front, cks_queue and cks_back.
//
// Usage: source text enters one byte per transfer on the push/full side,
// with final_byte marking the last byte of a text. After the last byte the
// weighted complexity score of that text appears on the pop/empty side.
// Throughput: one byte per cycle while a text streams and the queue has room;
// every byte but the last eight (all of a shorter text) is issued for judging
// as its seventh later byte arrives. After the last byte full stays high while
// the front drains its window, one held byte per cycle while the queue has room.
// With the output register free, empty falls after full falls, once the closing
// position has passed through the queue and been judged into the output register.
// The next text may start as soon as full falls; its bytes queue behind
// the previous one and never mix state with it.
// Reset clears the window fill count, nesting level, running score and output valid
// flag; the result side then reads empty. When the receiver stalls, the finished
// score stays in the output register, the back part keeps judging the next
// text until it reaches its end, and then the queue and input fill and
// full rises.
module cognitive_keyword_scorer #(
  parameter int SCORE_BITS = 24,
  parameter int NEST_BITS  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            text_byte,
  input  logic                  final_byte,
  output logic                  empty,
  input  logic                  pop,
  output logic [SCORE_BITS-1:0] score
);

  logic           q_full;
  logic           q_push;
  logic           q_empty;
  logic           q_pop;
  cks_pkg::item_t wr_item;
  cks_pkg::item_t rd_item;

  // Byte window and position issue.
  cks_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (wr_item)
  );

  // Decoupling queue.
  cks_queue #(
    .DEPTH (4)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_item (wr_item),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_item (rd_item),
    .q_empty (q_empty)
  );

  // Judge and score.
  cks_back #(
    .SCORE_BITS (SCORE_BITS),
    .NEST_BITS  (NEST_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_item  (rd_item),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .score   (score)
  );

endmodule

[test/tb.sv]
// Testbench for cognitive_keyword_scorer: a bit-exact predictor of the scorer
// checks every score transfer. Depends on cks_pkg and cognitive_keyword_scorer.
module tb;

  localparam int SCORE_W     = 24;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;

  // Predicts the score of each text and checks the scores that come out.
  class complexity_tracker;
    logic [7:0]         look [8];
    int unsigned        held;
    bit                 after_word;
    int unsigned        skip_cnt;
    logic [7:0]         depth;
    logic [SCORE_W-1:0] tally;
    bit                 line_has_s;
    logic [SCORE_W-1:0] due_scores [$];
    int                 errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      foreach (look[i]) look[i] = 8'h00;
      held       = 0;
      after_word = 1'b0;
      skip_cnt   = 0;
      depth      = 8'h00;
      tally      = '0;
      line_has_s = 1'b0;
    endfunction

    function bit alnum(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function string spelling(cks_pkg::kw_id_t id);
      string s;
      case (id)
        cks_pkg::KW_IF:     s = "if";
        cks_pkg::KW_ELSE:   s = "else";
        cks_pkg::KW_WHILE:  s = "while";
        cks_pkg::KW_FOR:    s = "for";
        cks_pkg::KW_DO:     s = "do";
        cks_pkg::KW_SWITCH: s = "switch";
        cks_pkg::KW_CATCH:  s = "catch";
        cks_pkg::KW_GOTO:   s = "goto";
        default:            s = "break";
      endcase
      return s;
    endfunction

    // Saturating add to the running score.
    function void bump(int unsigned amount);
      longint unsigned sum;
      sum = longint'(tally) + amount;
      if (sum > {SCORE_W{1'b1}}) begin
        tally = {SCORE_W{1'b1}};
      end else begin
        tally = sum[SCORE_W-1:0];
      end
    endfunction

    // A keyword matches when it is spelled out, fits before the end of the
    // text, and neither neighbor continues a word.
    function bit fits_keyword(string w, int unsigned avail);
      int unsigned n;
      logic [7:0]  nx;
      n = w.len();
      if (after_word || avail < n) return 1'b0;
      for (int i = 0; i < n; i++) begin
        if (look[i] != w[i]) return 1'b0;
      end
      if (avail > n) begin
        nx = look[n];
        if (alnum(nx) || nx == cks_pkg::CH_UNDER) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Scores the oldest held byte.
    function void rate_head(int unsigned avail);
      logic [7:0]      c;
      cks_pkg::kw_id_t id;
      string           w;
      c = look[0];
      if (c == cks_pkg::CH_LBRACE) begin
        if (depth != 8'hFF) depth++;
        return;
      end
      if (c == cks_pkg::CH_RBRACE) begin
        if (depth != 8'h00) depth--;
        return;
      end
      if (c == cks_pkg::CH_AMP || c == cks_pkg::CH_BAR) begin
        if (avail >= 2 && look[1] == c) begin
          bump(depth);
          skip_cnt = 1;
        end
        return;
      end
      for (int k = cks_pkg::KW_IF; k <= cks_pkg::KW_BREAK; k++) begin
        id = cks_pkg::kw_id_t'(k);
        w  = spelling(id);
        if (w[0] != c) continue;
        if (!fits_keyword(w, avail)) return;
        if (id == cks_pkg::KW_BREAK && !line_has_s) return;
        bump(depth + ((id == cks_pkg::KW_ELSE || id == cks_pkg::KW_GOTO ||
                       id == cks_pkg::KW_BREAK) ? 0 : 1));
        skip_cnt = w.len() - 1;
        return;
      end
    endfunction

    // Retires the oldest held byte; skipped bytes still update the context.
    function void retire_head();
      logic [7:0] c;
      c = look[0];
      if (skip_cnt > 0) begin
        skip_cnt--;
      end else begin
        rate_head(held);
      end
      after_word = alnum(c);
      if (c == cks_pkg::CH_LF) begin
        line_has_s = 1'b0;
      end else if (c == cks_pkg::CH_S) begin
        line_has_s = 1'b1;
      end
      for (int i = 0; i < 7; i++) look[i] = look[i+1];
      look[7] = 8'h00;
      held--;
    endfunction

    // Notes one accepted byte transfer.
    function void take_byte(logic [7:0] b, logic last);
      if (held >= 8) retire_head();
      look[held] = b;
      held++;
      if (!last) begin
        if (held >= 8) retire_head();
        return;
      end
      while (held > 0) retire_head();
      due_scores.push_back(tally);
      clear();
    endfunction

    // Checks one score transfer against the oldest expected score.
    function void match_score(logic [SCORE_W-1:0] got);
      logic [SCORE_W-1:0] want;
      if (due_scores.size() == 0) begin
        errors++;
        if (errors <= 10) $display("score transfer with none expected: got %0d", got);
        return;
      end
      want = due_scores.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("score mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [7:0]         text_byte = 8'h00;
  logic               final_byte = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [SCORE_W-1:0] score;

  complexity_tracker tracker = new();
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                hold_ticket = 0;
  int                hold_seen = 0;
  int                hold_left = 0;
  int                bytes_sent = 0;
  int                cycle_cnt = 0;
  logic [7:0]        draft [$];

  cognitive_keyword_scorer i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .empty      (empty),
    .pop        (pop),
    .score      (score)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both sides for transfers.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) tracker.take_byte(text_byte, final_byte);
      if (pop && !empty) tracker.match_score(score);
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("** cognitive_keyword_scorer: FAILED **");
    $finish;
  end

  // Offers one byte, with random idle cycles first, until it is transferred.
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    text_byte  <= b;
    final_byte <= last;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic send_word(string s, logic ends);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], ends && (i == s.len() - 1));
  endtask

  // Stops offering bytes and waits until every expected score has come.
  task automatic await_scores();
    push <= 1'b0;
    @(posedge clk);
    while (tracker.due_scores.size() != 0) @(posedge clk);
  endtask

  function automatic void draft_word(string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
  endfunction

  // Appends one token of code-like text, now and then a cut keyword or noise.
  function automatic void draft_token();
    int    r;
    string w;
    r = $urandom_range(99);
    if (r < 30) begin
      w = tracker.spelling(
            cks_pkg::kw_id_t'($urandom_range(cks_pkg::KW_BREAK, cks_pkg::KW_IF)));
      if ($urandom_range(9) == 0) w = w.substr(0, w.len() - 2);
      draft_word(w);
    end else if (r < 40) draft.push_back(cks_pkg::CH_LBRACE);
    else if (r < 48) draft.push_back(cks_pkg::CH_RBRACE);
    else if (r < 54) draft_word("&&");
    else if (r < 60) draft_word("||");
    else if (r < 63) draft.push_back($urandom_range(1) ? cks_pkg::CH_AMP : cks_pkg::CH_BAR);
    else if (r < 73) draft_word(" ");
    else if (r < 78) draft.push_back(cks_pkg::CH_LF);
    else if (r < 82) draft.push_back(cks_pkg::CH_S);
    else if (r < 90) draft.push_back(8'($urandom_range("z", "a")));
    else if (r < 93) draft.push_back(cks_pkg::CH_UNDER);
    else draft.push_back(8'($urandom_range(255)));
  endfunction

  task automatic send_random_text();
    int n_tok;
    int n;
    n_tok = $urandom_range(12, 1);
    draft.delete();
    for (int t = 0; t < n_tok; t++) draft_token();
    n = draft.size();
    for (int i = 0; i < n; i++) send_byte(draft[i], i == n - 1);
  endtask

  task automatic random_phase(int idle, int stall, int count);
    int target;
    idle_pct  = idle;
    stall_pct = stall;
    target    = bytes_sent + count;
    while (bytes_sent < target) send_random_text();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Short texts: keyword at the very end, braces, both pairs, break after
    // an 's', underflow of nesting, high bytes, a cut pair and a cut keyword.
    send_word("if", 1'b1);
    send_word("{if(a&&b||c)}", 1'b1);
    send_word("s{break}", 1'b1);
    send_byte(cks_pkg::CH_RBRACE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(cks_pkg::CH_AMP, 1'b1);
    send_word("xif_el", 1'b1);
    await_scores();

    // Nesting past its ceiling, then a keyword at the saturated level.
    for (int i = 0; i < 260; i++) send_byte(cks_pkg::CH_LBRACE, 1'b0);
    send_word(" if}do", 1'b1);
    await_scores();

    // The receiver holds off while texts keep coming, so the input fills up.
    hold_ticket++;
    for (int i = 0; i < 10; i++) send_random_text();
    await_scores();

    random_phase(0, 0, 120);
    random_phase(45, 0, 120);
    random_phase(0, 45, 120);
    random_phase(29, 29, 120);

    await_scores();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.due_scores.size() == 0) begin
      $display("** cognitive_keyword_scorer: PASSED **");
    end else begin
      $display("** cognitive_keyword_scorer: FAILED **");
    end
    $finish;
  end

endmodule
